@@ rtl/core/mtm_pkg.sv @@
// Package for the markup text minifier: character codes, skip kinds and the
// run-state struct shared by the judge logic and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtm_pkg;

   // configuration register
   localparam int unsigned LIMIT_WIDTH = 24;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 24'hFFFFFF;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LC_C   = 8'h63;
   localparam logic [7:0] CH_LC_I   = 8'h69;
   localparam logic [7:0] CH_LC_P   = 8'h70;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_S   = 8'h73;
   localparam logic [7:0] CH_LC_T   = 8'h74;

   // what the head byte is swallowed by
   typedef enum logic [1:0] {
      SKIP_NONE  = 2'd0,
      SKIP_SPACE = 2'd1,
      SKIP_LINE  = 2'd2,
      SKIP_REST  = 2'd3
   } skip_type;

   // tracking flags of one text run
   typedef struct packed {
      logic     script;
      logic     quote;
      logic     block;
      logic     markup;
      skip_type skip;
   } run_type;

endpackage : mtm_pkg

`default_nettype wire

@@ rtl/core/markup_text_minifier_top.sv @@
// Top level of the markup text minifier: lookahead window, run state,
// end-of-text drain, result register and configuration register.
// Depends on mtm_pkg and mtm_judge.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | req_in_byte, req_in_last
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_out_byte, rsp_out_last
//  csr     | in        | csr_valid/csr_ready  | csr_position_limit
//
// One byte is taken per cycle while req_ready is high; the judge works on the
// window as it stands after the new byte, and a kept byte lands in the result
// register the same edge. A byte marked last then drains the window, retiring
// one to three head bytes per step, before req_ready returns. During the drain
// each kept byte is held in a hold register so that the last one's last flag
// is known. A stalled result blocks both the input and the drain.
// Reset is synchronous; the limit resets to all ones.
`timescale 1ns / 1ps
`default_nettype none

module markup_text_minifier_top
   import mtm_pkg::*;
#(
   parameter int unsigned LOOKAHEAD_DEPTH = 8,
   parameter int unsigned POSITION_WIDTH  = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_in_byte,
   input  wire logic                   req_in_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_out_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [LIMIT_WIDTH-1:0] csr_position_limit
);

   localparam int unsigned D  = LOOKAHEAD_DEPTH;
   localparam int unsigned FW = $clog2(D + 1);
   localparam int unsigned PW = POSITION_WIDTH;

   logic [7:0]             win_ff [D];
   logic [7:0]             win_in [D];
   logic [FW-1:0]          fill_ff, fill_in;
   logic [PW-1:0]          pos_ff, pos_in;
   run_type                run_ff, run_in;
   logic                   drain_ff, drain_in;
   logic                   hold_valid_ff, hold_valid_in;
   logic [7:0]             hold_byte_ff, hold_byte_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;

   logic [7:0]             pushed [D];
   logic [FW-1:0]          fill_push;
   logic [7:0]             jwin [D];
   logic [FW-1:0]          jfill;
   logic [7:0]             srcx [D+3];
   logic [7:0]             shifted [D];
   logic [PW:0]            pos_sum;
   logic [PW-1:0]          pos_sat;
   logic                   out_free;
   logic                   req_xfer;
   logic                   drain_go;
   logic                   drain_end;
   logic                   keep;
   logic [7:0]             keep_byte;
   logic [1:0]             pop_n;
   run_type                new_run;

   // handshakes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !drain_ff && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign drain_go  = drain_ff && out_free && fill_ff != '0;
   assign drain_end = drain_ff && out_free && fill_ff == '0;
   assign csr_ready = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   // window with the incoming byte appended
   always_comb begin
      for (int k = 0; k < D; k++) begin
         pushed[k] = (FW'(k) == fill_ff) ? req_in_byte : win_ff[k];
      end
   end
   assign fill_push = (fill_ff < FW'(D)) ? fill_ff + FW'(1) : fill_ff;

   // judge sees the appended window on input, the stored one while draining
   always_comb begin
      for (int k = 0; k < D; k++) begin
         jwin[k] = drain_ff ? win_ff[k] : pushed[k];
      end
   end
   assign jfill = drain_ff ? fill_ff : fill_push;

   mtm_judge #(
      .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
      .POSITION_WIDTH  (POSITION_WIDTH)
   ) u_judge (
      .win       (jwin),
      .fill      (jfill),
      .pos       (pos_ff),
      .limit     (limit_ff),
      .cur_run   (run_ff),
      .keep      (keep),
      .keep_byte (keep_byte),
      .pop_n     (pop_n),
      .new_run   (new_run)
   );

   // window shift by the number of retired bytes
   always_comb begin
      for (int k = 0; k < D + 3; k++) begin
         srcx[k] = (k < D) ? jwin[k % D] : 8'h00;
      end
      for (int k = 0; k < D; k++) begin
         case (pop_n)
            2'd0:    shifted[k] = srcx[k];
            2'd1:    shifted[k] = srcx[k+1];
            2'd2:    shifted[k] = srcx[k+2];
            2'd3:    shifted[k] = srcx[k+3];
            default: shifted[k] = srcx[k];
         endcase
      end
   end

   // saturating head position
   assign pos_sum = {1'b0, pos_ff} + (PW+1)'(pop_n);
   assign pos_sat = pos_sum[PW] ? {PW{1'b1}} : pos_sum[PW-1:0];

   // next state
   always_comb begin
      win_in        = win_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      run_in        = run_ff;
      drain_in      = drain_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      limit_in      = csr_valid ? csr_position_limit : limit_ff;
      if (req_xfer) begin
         win_in  = pushed;
         fill_in = fill_push;
         if (req_in_last) begin
            drain_in = 1'b1;
         end else if (fill_push == FW'(D)) begin
            win_in  = shifted;
            fill_in = fill_push - FW'(pop_n);
            pos_in  = pos_sat;
            run_in  = new_run;
            if (keep) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = keep_byte;
               rsp_last_in  = 1'b0;
            end
         end
      end else if (drain_go) begin
         win_in  = shifted;
         fill_in = fill_ff - FW'(pop_n);
         pos_in  = pos_sat;
         run_in  = new_run;
         if (keep) begin
            if (hold_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_byte_ff;
               rsp_last_in  = 1'b0;
            end
            hold_valid_in = 1'b1;
            hold_byte_in  = keep_byte;
         end
      end else if (drain_end) begin
         // flush the held byte as the final transfer, then clear the run
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = hold_byte_ff;
            rsp_last_in  = 1'b1;
         end
         hold_valid_in = 1'b0;
         fill_in       = '0;
         pos_in        = '0;
         run_in        = '0;
         drain_in      = 1'b0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      hold_byte_ff <= hold_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         fill_ff       <= '0;
         pos_ff        <= '0;
         run_ff        <= '0;
         drain_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         run_ff        <= run_in;
         drain_ff      <= drain_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_ff      <= limit_in;
      end
   end

   // window never overfills, and is below full whenever input is open
   assert property (@(posedge clock) disable iff (reset)
      !drain_ff |-> fill_ff < FW'(D))
      else $error("window full outside drain");

   // a held byte exists only while draining
   assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> drain_ff)
      else $error("held byte outside drain");

   // the run is empty once a drain completes
   assert property (@(posedge clock) disable iff (reset)
      $fell(drain_ff) |-> (fill_ff == '0 && pos_ff == '0 && !hold_valid_ff))
      else $error("run not cleared after drain");

   // a transfer with the last flag is only produced at the end of a drain
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_last_ff |-> $fell(drain_ff))
      else $error("last flag outside drain end");

endmodule : markup_text_minifier_top

`default_nettype wire

@@ rtl/core/mtm_judge.sv @@
// Head-byte judge of the markup text minifier: decides keep or drop for the
// window head, how many bytes leave the window, and the next run flags.
// Depends on mtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtm_judge
   import mtm_pkg::*;
#(
   parameter int unsigned LOOKAHEAD_DEPTH = 8,
   parameter int unsigned POSITION_WIDTH  = 24
) (
   input  wire logic [7:0]                         win      [LOOKAHEAD_DEPTH],
   input  wire logic [$clog2(LOOKAHEAD_DEPTH+1)-1:0] fill,
   input  wire logic [POSITION_WIDTH-1:0]          pos,
   input  wire logic [LIMIT_WIDTH-1:0]             limit,
   input  wire run_type                            cur_run,
   output logic                                    keep,
   output logic [7:0]                              keep_byte,
   output logic [1:0]                              pop_n,
   output run_type                                 new_run
);

   localparam int unsigned FW = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam int unsigned CW = ((POSITION_WIDTH > LIMIT_WIDTH) ?
                                 POSITION_WIDTH : LIMIT_WIDTH) + 4;

   typedef struct packed {
      logic keep;
      logic script;
      logic quote;
      logic markup;
   } tail_type;

   // quote, markup-comment and script tests on a seven-byte view
   function automatic tail_type tail_eval(input logic [6:0][7:0] v,
                                          input logic [6:0]      ok,
                                          input logic [CW-1:0]   ib,
                                          input logic [CW-1:0]   lw,
                                          input run_type         r);
      tail_type t;
      logic     in_range;
      logic     open_mk;
      logic     close_mk;
      logic     open_sc;
      logic     close_sc;
      t.script = r.script;
      t.quote  = r.quote ^ (v[0] == CH_DQUOTE || v[0] == CH_SQUOTE);
      open_mk  = ok[0] && v[0] == CH_LT && ok[1] && v[1] == CH_BANG &&
                 ok[2] && v[2] == CH_DASH && ok[3] && v[3] == CH_DASH;
      close_mk = ok[0] && v[0] == CH_DASH && ok[1] && v[1] == CH_DASH &&
                 ok[2] && v[2] == CH_GT;
      t.markup = r.markup || open_mk;
      if (t.markup && close_mk) begin
         t.markup = 1'b0;
      end
      t.keep   = !t.markup;
      open_sc  = ok[0] && v[0] == CH_LT && ok[1] && v[1] == CH_LC_S &&
                 ok[2] && v[2] == CH_LC_C && ok[3] && v[3] == CH_LC_R &&
                 ok[4] && v[4] == CH_LC_I && ok[5] && v[5] == CH_LC_P &&
                 ok[6] && v[6] == CH_LC_T;
      close_sc = ok[0] && v[0] == CH_LT && ok[1] && v[1] == CH_SLASH &&
                 ok[2] && v[2] == CH_LC_S && ok[3] && v[3] == CH_LC_C &&
                 ok[4] && v[4] == CH_LC_R && ok[5] && v[5] == CH_LC_I &&
                 ok[6] && v[6] == CH_LC_P;
      in_range = (ib + CW'(7)) < lw;
      if (t.keep) begin
         if (in_range && !t.script && !t.quote && open_sc) begin
            t.script = 1'b1;
         end
         if (in_range && t.script && !t.quote && close_sc) begin
            t.script = 1'b0;
         end
      end
      return t;
   endfunction

   logic [7:0]      wx [LOOKAHEAD_DEPTH+2];
   logic [8:0]      vm;
   logic [6:0][7:0] view0;
   logic [6:0][7:0] view2;
   logic [6:0]      ok0;
   logic [6:0]      ok2;
   logic [CW-1:0]   iw;
   logic [CW-1:0]   lw;
   logic [7:0]      h;
   logic            space_run;
   logic            line_cmt;
   logic            blk;
   logic            star_slash;
   tail_type        t0;
   tail_type        t2;

   // padded window, valid mask and the two views (head, and head after two)
   always_comb begin
      for (int k = 0; k < LOOKAHEAD_DEPTH + 2; k++) begin
         wx[k] = (k < LOOKAHEAD_DEPTH) ? win[k % LOOKAHEAD_DEPTH] : 8'h00;
      end
      for (int k = 0; k < 9; k++) begin
         vm[k] = FW'(k) < fill;
      end
      for (int k = 0; k < 7; k++) begin
         view0[k] = wx[k];
         view2[k] = wx[k+2];
         ok0[k]   = vm[k];
         ok2[k]   = vm[k+2];
      end
   end

   assign iw = CW'(pos);
   assign lw = CW'(limit);
   assign h  = wx[0];

   // pattern tests on the head
   always_comb begin
      space_run = 1'b1;
      for (int k = 0; k < 4; k++) begin
         space_run = space_run && vm[k] && wx[k] == CH_SPACE && (iw + CW'(k)) < lw;
      end
   end

   assign line_cmt   = cur_run.script && !cur_run.quote && (lw > iw + CW'(2)) &&
                       vm[0] && wx[0] == CH_SLASH && vm[1] && wx[1] == CH_SLASH;
   assign blk        = cur_run.block ||
                       (vm[0] && wx[0] == CH_SLASH && vm[1] && wx[1] == CH_STAR);
   assign star_slash = vm[0] && wx[0] == CH_STAR && vm[1] && wx[1] == CH_SLASH;

   assign t0 = tail_eval(view0, ok0, iw, lw, cur_run);
   assign t2 = tail_eval(view2, ok2, iw + CW'(2), lw, cur_run);

   // decision
   always_comb begin
      keep      = 1'b0;
      keep_byte = h;
      pop_n     = 2'd1;
      new_run   = cur_run;
      if (cur_run.skip == SKIP_REST || iw >= lw) begin
         // dropped, flags unchanged
      end else if (cur_run.skip == SKIP_LINE) begin
         if (h == CH_LF || h == CH_CR) begin
            new_run.skip = SKIP_NONE;
         end
      end else begin
         new_run.skip = SKIP_NONE;
         if (cur_run.skip == SKIP_SPACE && h == CH_SPACE) begin
            new_run.skip = SKIP_SPACE;
         end else if (h == CH_CR || h == CH_LF || h == CH_TAB) begin
            // whitespace control dropped
         end else if (space_run) begin
            new_run.skip = SKIP_SPACE;
            keep         = 1'b1;
            keep_byte    = CH_SPACE;
         end else if (line_cmt) begin
            new_run.skip = SKIP_LINE;
         end else if (blk && star_slash) begin
            pop_n = 2'd2;
            if (lw < iw + CW'(4)) begin
               new_run.skip  = SKIP_REST;
               new_run.block = 1'b1;
            end else begin
               new_run.block = 1'b0;
               if (fill > FW'(2)) begin
                  pop_n          = 2'd3;
                  keep           = t2.keep;
                  keep_byte      = wx[2];
                  new_run.quote  = t2.quote;
                  new_run.markup = t2.markup;
                  new_run.script = t2.script;
               end
            end
         end else if (blk) begin
            new_run.block = 1'b1;
         end else begin
            keep           = t0.keep;
            new_run.quote  = t0.quote;
            new_run.markup = t0.markup;
            new_run.script = t0.script;
         end
      end
   end

endmodule : mtm_judge

`default_nettype wire
